@@ rtl/overwrite_ring_buffer_core_defines.svh @@
// ---------------------------------------------------------------------------
// Overwrite ring buffer: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef OVERWRITE_RING_BUFFER_CORE_DEFINES_SVH
`define OVERWRITE_RING_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication.
`define ORB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ORB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/orb_pkg.sv @@
// ---------------------------------------------------------------------------
// orb_pkg
// Types and constants shared by the ring buffer controller and datapath.
// ---------------------------------------------------------------------------
package orb_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 64;

  localparam int ENTRY_W = 64;  // entry_word / entry_out field width
  localparam int CNT_W   = 7;   // capacity, counts and ring indices
  localparam int FUNC_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  typedef struct packed {
    logic append;
    logic list_start;
    logic remove;
    logic issue;       // read one entry of the list run
  } orb_cmd_t;

  typedef struct packed {
    logic held_zero;
    logic can_issue;   // read slot free for one more entry
    logic last_pending; // next read is the newest entry
  } orb_status_t;

endpackage

@@ rtl/orb_ctrl.sv @@
// ---------------------------------------------------------------------------
// orb_ctrl
// Request decode and list-run sequencing for the ring buffer.
// ---------------------------------------------------------------------------
module orb_ctrl
  import orb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FUNC_W-1:0] in_func,
  input  orb_status_t       st,
  output orb_cmd_t          cmd
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd            = '0;
    cmd.append     = accept && (in_func == FUNC_APPEND);
    cmd.list_start = accept && (in_func == FUNC_LIST) && !st.held_zero;
    cmd.remove     = accept && (in_func == FUNC_REMOVE);
    cmd.issue      = (state_r == S_LIST) && st.can_issue;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.list_start) state_nxt = S_LIST;
      end
      S_LIST: begin
        // release input once the newest entry is read
        if (cmd.issue && st.last_pending) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/orb_dp.sv @@
// ---------------------------------------------------------------------------
// orb_dp
// Ring pointers, entry memory and the output register of the ring buffer.
// ---------------------------------------------------------------------------
module orb_dp
  import orb_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic [ENTRY_W-1:0] in_entry_word,
  input  logic [CNT_W-1:0]   in_drop_count,
  input  orb_cmd_t           cmd,
  output orb_status_t        st,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ENTRY_W-1:0] out_entry,
  output logic               out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] CAP_RST =
    (int'(CAP_RESET) > DEPTH) ? CNT_W'(DEPTH) : CAP_RESET;

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic             rd_last_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic             out_v_r, out_v_nxt;
  logic             out_last_r;
  logic [WORD_BITS-1:0] out_data_r;

  logic [CNT_W-1:0] cfg_cap;
  logic [CNT_W-1:0] drop;
  logic [CNT_W-1:0] held_less;
  logic [CNT_W:0]   head_sum;
  logic [CNT_W-1:0] head_drop;
  logic             load_out;

  function automatic logic [CNT_W-1:0] ring_inc(input logic [CNT_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nx;
    nx = idx + 1'b1;
    return (nx == cap) ? '0 : nx;
  endfunction

  // saturate the written capacity to 1..DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (int'(cfg_wdata) > DEPTH) begin
      cfg_cap = CNT_W'(DEPTH);
    end else begin
      cfg_cap = cfg_wdata;
    end
  end

  assign drop      = (in_drop_count > held_r) ? held_r : in_drop_count;
  assign held_less = held_r - drop;
  assign head_sum  = {1'b0, head_r} + {1'b0, drop};
  assign head_drop = (head_sum >= {1'b0, cap_r}) ? CNT_W'(head_sum - {1'b0, cap_r})
                                                  : head_sum[CNT_W-1:0];

  assign load_out = rd_v_r && (!out_v_r || out_tready);

  assign st.held_zero    = (held_r == '0);
  assign st.can_issue    = !rd_v_r || !out_v_r || out_tready;
  assign st.last_pending = (rem_r == CNT_W'(1));

  always_comb begin
    cap_nxt  = cap_r;
    head_nxt = head_r;
    wr_nxt   = wr_r;
    held_nxt = held_r;
    rd_nxt   = rd_r;
    rem_nxt  = rem_r;
    if (cfg_we) begin
      cap_nxt  = cfg_cap;
      head_nxt = '0;
      wr_nxt   = '0;
      held_nxt = '0;
    end else if (cmd.append) begin
      // full ring: drop the oldest
      if (held_r < cap_r) begin
        held_nxt = held_r + 1'b1;
      end else begin
        head_nxt = ring_inc(head_r, cap_r);
      end
      wr_nxt = ring_inc(wr_r, cap_r);
    end else if (cmd.remove) begin
      held_nxt = held_less;
      if (held_less == '0) begin
        head_nxt = '0;
        wr_nxt   = '0;
      end else begin
        head_nxt = head_drop;
      end
    end else if (cmd.list_start) begin
      rd_nxt  = head_r;
      rem_nxt = held_r;
    end else if (cmd.issue) begin
      rd_nxt  = ring_inc(rd_r, cap_r);
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_comb begin
    rd_v_nxt = rd_v_r;
    if (cmd.issue) begin
      rd_v_nxt = 1'b1;
    end else if (load_out) begin
      rd_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RST;
      head_r  <= '0;
      wr_r    <= '0;
      held_r  <= '0;
      rd_r    <= '0;
      rem_r   <= '0;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      wr_r    <= wr_nxt;
      held_r  <= held_nxt;
      rd_r    <= rd_nxt;
      rem_r   <= rem_nxt;
      rd_v_r  <= rd_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[AW'(wr_r)] <= in_entry_word[WORD_BITS-1:0];
    end
    if (cmd.issue) begin
      rd_data_r <= mem[AW'(rd_r)];
      rd_last_r <= st.last_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= rd_data_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_entry  = ENTRY_W'(out_data_r);
  assign out_last   = out_last_r;

endmodule

@@ rtl/overwrite_ring_buffer_core.sv @@
// ---------------------------------------------------------------------------
// overwrite_ring_buffer_core
// Ring buffer of up to capacity entries that overwrites the oldest when full.
// ---------------------------------------------------------------------------
// Requests arrive on the in_ stream: in_tuser carries the function (append,
// list, remove), in_tdata the entry word and the drop count. Append and
// remove requests produce nothing. A list request of
// n held entries streams them on the out_ stream, oldest first, with
// out_tlast on the newest; an empty ring lists nothing.
// The first entry of a list passes the list state, the read and the output
// registers after the request is accepted; entries then follow one per cycle
// while out_tready is high, set by the single read port of the entry memory.
// in_tready stays low after a list request until the newest entry is read.
// A stalled out_tready holds the output register and one read in flight;
// reading pauses until the receiver takes the entry.
// cfg_we writes the capacity (0 acts as 1, above DEPTH as DEPTH) and empties
// the ring. Reset empties the ring and sets capacity to 64 (or DEPTH if
// smaller); the entry memory is not cleared.
// ---------------------------------------------------------------------------
`include "overwrite_ring_buffer_core_defines.svh"

module overwrite_ring_buffer_core
  import orb_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_wdata,   // capacity
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,    // [63:0] entry_word, [70:64] drop_count, [71] zero
  input  logic [FUNC_W-1:0]    in_tuser,    // [1:0] func
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ENTRY_W-1:0]   out_tdata,   // [63:0] entry_out
  output logic                 out_tlast    // last_entry
);

  orb_cmd_t    cmd;
  orb_status_t st;

  orb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .st        (st),
    .cmd       (cmd)
  );

  orb_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_entry_word (in_tdata[ENTRY_W-1:0]),
    .in_drop_count (in_tdata[ENTRY_W+CNT_W-1:ENTRY_W]),
    .cmd           (cmd),
    .st            (st),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_entry     (out_tdata),
    .out_last      (out_tlast)
  );

  `ORB_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0(cmd), "ring commands overlap")
  `ORB_ASSERT_NEXT(a_list_holds_input, cmd.list_start, !in_tready, "input open during list run")
  `ORB_ASSERT_NEXT(a_last_frees, cmd.issue && st.last_pending, in_tready, "input not released")

endmodule

@@ tb/ring_list_checker.sv @@
// ---------------------------------------------------------------------------
// ring_list_checker
// Watches the request, list and capacity ports of the overwrite ring buffer,
// keeps its own copy of the ring, and compares every listed entry in order.
// ---------------------------------------------------------------------------
module ring_list_checker
  import orb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [71:0]        in_tdata,    // [63:0] entry_word, [70:64] drop_count, [71] zero
  input  logic [FUNC_W-1:0]  in_tuser,    // [1:0] func
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [ENTRY_W-1:0] out_tdata,   // [63:0] entry_out
  input  logic               out_tlast,   // last_entry
  output int unsigned        fail_count,
  output int unsigned        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               last;
  } listed_entry_t;

  listed_entry_t      listed_q[$];
  logic [ENTRY_W-1:0] ring_mem [DEPTH_DEF];
  logic [CNT_W-1:0]   capacity;
  logic [CNT_W-1:0]   head_idx;
  logic [CNT_W-1:0]   wr_idx;
  logic [CNT_W-1:0]   held;

  function automatic int unsigned ring_size();
    if (capacity == '0) return 1;
    if (int'(capacity) > DEPTH_DEF) return DEPTH_DEF;
    return int'(capacity);
  endfunction

  task automatic empty_ring();
    held     = '0;
    head_idx = '0;
    wr_idx   = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [ENTRY_W-1:0] got,
                                 input logic [ENTRY_W-1:0] want);
    if (fail_count < 50) begin
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [ENTRY_W-1:0] word,
                               input logic [CNT_W-1:0] drop);
    int unsigned   cap;
    int unsigned   k;
    int unsigned   d;
    listed_entry_t item;
    cap = ring_size();
    // keep the indices inside the ring
    head_idx = CNT_W'(int'(head_idx) % cap);
    wr_idx   = CNT_W'(int'(wr_idx) % cap);
    if (int'(held) > cap) held = CNT_W'(cap);
    case (func)
      FUNC_APPEND: begin
        if (int'(held) < cap) held = held + 1'b1;
        else head_idx = CNT_W'((int'(head_idx) + 1) % cap);
        ring_mem[wr_idx] = word;
        wr_idx = CNT_W'((int'(wr_idx) + 1) % cap);
      end
      FUNC_LIST: begin
        for (k = 0; k < int'(held); k++) begin
          item.entry = ring_mem[(int'(head_idx) + k) % cap];
          item.last  = (k + 1 == int'(held));
          listed_q.push_back(item);
        end
      end
      FUNC_REMOVE: begin
        d = (int'(drop) > int'(held)) ? int'(held) : int'(drop);
        held     = CNT_W'(int'(held) - d);
        head_idx = CNT_W'((int'(head_idx) + d) % cap);
        if (held == '0) empty_ring();
      end
      default: ;  // unused function code: drop the request
    endcase
  endtask

  task automatic check_listed(input logic [ENTRY_W-1:0] entry, input logic last);
    listed_entry_t want;
    if (listed_q.size() == 0) begin
      report_mismatch("entry with nothing listed", entry, '0);
    end else begin
      want = listed_q.pop_front();
      if (entry !== want.entry) report_mismatch("entry_out", entry, want.entry);
      if (last !== want.last) report_mismatch("last_entry", ENTRY_W'(last), ENTRY_W'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity = CAP_RESET;
      empty_ring();
      listed_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) check_listed(out_tdata, out_tlast);
      if (cfg_we) begin
        capacity = cfg_wdata;
        empty_ring();
      end
      if (in_tvalid && in_tready) apply_request(in_tuser, in_tdata[63:0], in_tdata[70:64]);
    end
    pending <= listed_q.size();
  end

endmodule

@@ tb/overwrite_ring_buffer_core_tb.sv @@
// ---------------------------------------------------------------------------
// overwrite_ring_buffer_core_tb
// Drives append, list and remove requests through several capacities with
// bursty input and a stalling receiver; a side checker scores the lists.
// ---------------------------------------------------------------------------
module overwrite_ring_buffer_core_tb
  import orb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT      = 4000;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 6;
  localparam int RANDOM_PER_PHASE = 35;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [71:0]        in_tdata;    // [63:0] entry_word, [70:64] drop_count, [71] zero
  logic [FUNC_W-1:0]  in_tuser;    // [1:0] func
  logic               out_tvalid;
  logic               out_tready;
  logic [ENTRY_W-1:0] out_tdata;   // [63:0] entry_out
  logic               out_tlast;   // last_entry
  int unsigned        fail_count;
  int unsigned        pending;
  logic               hold_req;
  int                 burst_left;
  int                 idle_cycles;

  overwrite_ring_buffer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ring_list_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // end the run when no handshake moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // receiver: switch stall pattern at random, hold off on request
  initial begin
    rx_mode_t mode;
    int       span;
    int       period;
    int       tick;
    logic     hold_done;
    hold_done = 1'b0;
    forever begin
      mode   = rx_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(16, 80);
      period = $urandom_range(2, 6);
      for (tick = 0; tick < span; tick++) begin
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_OPEN:     out_tready <= 1'b1;
          RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_tready <= (tick % period == 0);
          default:     out_tready <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [ENTRY_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] random_drop();
    if ($urandom_range(0, 4) != 0) return CNT_W'($urandom_range(0, 4));
    return CNT_W'($urandom_range(0, 127));
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [ENTRY_W-1:0] word,
                              input logic [CNT_W-1:0] drop);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {1'b0, drop, word};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_func(input logic [FUNC_W-1:0] func);
    send_request(func, random_word(), CNT_W'($urandom_range(0, 127)));
  endtask

  // wait until every listed entry is out and the last request has retired
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly append runs closed by a list, with noise requests mixed in
  task automatic run_random(input int count);
    int done;
    int k;
    logic [FUNC_W-1:0] func;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(1, 12);
        repeat (k) send_func(FUNC_APPEND);
        done += k;
        if ($urandom_range(0, 2) == 0) begin
          send_request(FUNC_REMOVE, random_word(), random_drop());
          done++;
        end
        send_func(FUNC_LIST);
        done++;
      end else begin
        func = FUNC_W'($urandom_range(0, 3));
        if (func == FUNC_REMOVE) send_request(func, random_word(), random_drop());
        else send_func(func);
        if (func != FUNC_UNUSED) done++;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_APPEND;
    hold_req   = 1'b0;
    burst_left = $urandom_range(1, 40);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty ring, saturating drops, unused code
    send_func(FUNC_LIST);
    send_request(FUNC_REMOVE, random_word(), 7'd5);
    send_request(FUNC_APPEND, '1, random_drop());
    send_request(FUNC_APPEND, '0, random_drop());
    send_func(FUNC_APPEND);
    send_func(FUNC_UNUSED);
    send_func(FUNC_LIST);
    send_request(FUNC_REMOVE, random_word(), 7'd0);
    send_func(FUNC_LIST);
    send_request(FUNC_REMOVE, random_word(), 7'd127);
    send_func(FUNC_LIST);
    send_func(FUNC_APPEND);
    send_func(FUNC_APPEND);
    send_request(FUNC_REMOVE, random_word(), 7'd1);
    send_func(FUNC_LIST);

    // single-entry ring: each append to the full ring overwrites
    write_capacity(7'd1);
    send_func(FUNC_APPEND);
    send_func(FUNC_APPEND);
    send_func(FUNC_LIST);
    send_request(FUNC_REMOVE, random_word(), 7'd1);
    send_func(FUNC_LIST);
    run_random(RANDOM_PER_PHASE);

    // zero capacity acts as one
    write_capacity(7'd0);
    send_func(FUNC_APPEND);
    send_func(FUNC_APPEND);
    send_func(FUNC_LIST);
    run_random(RANDOM_PER_PHASE);

    // oversized capacity clamps to the ring depth
    write_capacity(7'd127);
    run_random(RANDOM_PER_PHASE);

    // full ring with wrap, then a long list against a held-off receiver
    write_capacity(7'd64);
    repeat (66) send_func(FUNC_APPEND);
    hold_req = 1'b1;
    send_func(FUNC_LIST);
    repeat (4) send_func(FUNC_APPEND);
    send_func(FUNC_LIST);
    run_random(RANDOM_PER_PHASE);

    write_capacity(7'd3);
    run_random(RANDOM_PER_PHASE);

    write_capacity(CNT_W'($urandom_range(2, 63)));
    run_random(RANDOM_PER_PHASE);

    write_capacity(CNT_W'($urandom_range(0, 127)));
    run_random(RANDOM_PER_PHASE);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
